// ===== src/mfe_pkg.sv =====
// ----------------------------------------------------------------------------
// mfe_pkg
// Shared constants and types for the most-frequent-element finder.
// ----------------------------------------------------------------------------
package mfe_pkg;

  localparam int unsigned DefStoreDepth = 128;
  localparam int unsigned ValueW        = 32;
  localparam int unsigned ModeCountW    = 8;

  // sequencer states, one-hot
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PIV   = 6'b000010,
    S_LATCH = 6'b000100,
    S_SCAN  = 6'b001000,
    S_NEXT  = 6'b010000,
    S_EMIT  = 6'b100000
  } seq_state_t;

endpackage

// ===== src/most_frequent_element_finder.sv =====
// ----------------------------------------------------------------------------
// most_frequent_element_finder
// Collects a set of signed 32-bit elements and reports its mode.
// ----------------------------------------------------------------------------
// Input: a transaction is taken on a clock edge with start high and busy low.
// Each one may carry an element (in_carries_value) and may close the set
// (in_last_item). Each element is written to the store as it is taken; elements beyond
// STORE_DEPTH are dropped and flagged as overflowed.
// After the closing transaction busy stays high for the count pass, which
// reads each stored element in turn as the pivot and compares it with every
// later element; the result is then registered.
// An empty set skips the pass and reports value 0, count 0.
// Output: out_valid is high for exactly one cycle with the mode value, its
// count (saturated at 255) and the overflow flag. The receiver cannot stall;
// the result register is separate, so busy drops as the strobe goes out and
// the next set can start loading at once.
// Reset (synchronous, active low) empties the set and clears the flag; the
// store contents are not cleared, only written entries are read.
// ----------------------------------------------------------------------------
module most_frequent_element_finder import mfe_pkg::*; #(
  parameter int unsigned STORE_DEPTH = DefStoreDepth
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [ValueW-1:0]     in_value,
  input  logic                         in_last_item,
  input  logic                         in_carries_value,
  output logic                         out_valid,
  output logic signed [ValueW-1:0]     out_mode_value,
  output logic [ModeCountW-1:0]        out_mode_count,
  output logic                         out_overflowed
);

  localparam int unsigned AW = $clog2(STORE_DEPTH);

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [ValueW-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [ValueW-1:0] mem_rdata;
  logic [ValueW-1:0] mode_value;

  mfe_store #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  mfe_seq #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_value         (in_value),
    .in_last_item     (in_last_item),
    .in_carries_value (in_carries_value),
    .out_valid        (out_valid),
    .out_mode_value   (mode_value),
    .out_mode_count   (out_mode_count),
    .out_overflowed   (out_overflowed),
    .mem_we           (mem_we),
    .mem_waddr        (mem_waddr),
    .mem_wdata        (mem_wdata),
    .mem_re           (mem_re),
    .mem_raddr        (mem_raddr),
    .mem_rdata        (mem_rdata)
  );

  assign out_mode_value = mode_value;

endmodule

// ===== src/mfe_store.sv =====
// ----------------------------------------------------------------------------
// mfe_store
// Element store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mfe_store import mfe_pkg::*; #(
  parameter int unsigned STORE_DEPTH = DefStoreDepth,
  localparam int unsigned AW = $clog2(STORE_DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [ValueW-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [ValueW-1:0] rdata
);

  logic [ValueW-1:0] mem [STORE_DEPTH];
  logic [ValueW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/mfe_seq.sv =====
// ----------------------------------------------------------------------------
// mfe_seq
// Load control and triangular count sequencer over the element store.
// ----------------------------------------------------------------------------
module mfe_seq import mfe_pkg::*; #(
  parameter int unsigned STORE_DEPTH = DefStoreDepth,
  localparam int unsigned AW = $clog2(STORE_DEPTH),
  localparam int unsigned CW = $clog2(STORE_DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [ValueW-1:0]     in_value,
  input  logic                  in_last_item,
  input  logic                  in_carries_value,
  output logic                  out_valid,
  output logic [ValueW-1:0]     out_mode_value,
  output logic [ModeCountW-1:0] out_mode_count,
  output logic                  out_overflowed,
  // store ports
  output logic                  mem_we,
  output logic [AW-1:0]         mem_waddr,
  output logic [ValueW-1:0]     mem_wdata,
  output logic                  mem_re,
  output logic [AW-1:0]         mem_raddr,
  input  logic [ValueW-1:0]     mem_rdata
);

  seq_state_t state_r, state_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic          ovf_r, ovf_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic          rv_r, rv_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] best_cnt_r, best_cnt_nxt;
  logic [ValueW-1:0] best_val_r, best_val_nxt;
  logic [ValueW-1:0] pivot_r, pivot_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [ValueW-1:0] out_value_r, out_value_nxt;
  logic [ModeCountW-1:0] out_count_r, out_count_nxt;
  logic          out_ovf_r, out_ovf_nxt;
  logic          accept;
  logic          room;
  logic [CW-1:0] i_inc;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign room   = (fill_r < CW'(STORE_DEPTH));
  assign i_inc  = i_r + CW'(1);

  assign mem_we    = accept && in_carries_value && room;
  assign mem_waddr = fill_r[AW-1:0];
  assign mem_wdata = in_value;

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    ovf_nxt       = ovf_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    rv_nxt        = rv_r;
    cnt_nxt       = cnt_r;
    best_cnt_nxt  = best_cnt_r;
    best_val_nxt  = best_val_r;
    pivot_nxt     = pivot_r;
    out_valid_nxt = 1'b0;
    out_value_nxt = out_value_r;
    out_count_nxt = out_count_r;
    out_ovf_nxt   = out_ovf_r;
    mem_re        = 1'b0;
    mem_raddr     = j_r[AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (mem_we) begin
            fill_nxt = fill_r + CW'(1);
          end else if (in_carries_value) begin
            ovf_nxt = 1'b1;
          end
          if (in_last_item) begin
            best_cnt_nxt = '0;
            best_val_nxt = '0;
            i_nxt        = '0;
            state_nxt    = (fill_nxt == '0) ? S_EMIT : S_PIV;
          end
        end
      end
      S_PIV: begin
        mem_re    = 1'b1;
        mem_raddr = i_r[AW-1:0];
        state_nxt = S_LATCH;
      end
      S_LATCH: begin
        pivot_nxt = mem_rdata;
        cnt_nxt   = CW'(1);
        j_nxt     = i_inc;
        rv_nxt    = 1'b0;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        // compare data from the read issued last cycle, issue the next one
        if (rv_r && (mem_rdata == pivot_r)) begin
          cnt_nxt = cnt_r + CW'(1);
        end
        if (j_r < fill_r) begin
          mem_re = 1'b1;
          j_nxt  = j_r + CW'(1);
          rv_nxt = 1'b1;
        end else begin
          rv_nxt    = 1'b0;
          state_nxt = S_NEXT;
        end
      end
      S_NEXT: begin
        // strictly larger only: earliest value keeps ties
        if (cnt_r > best_cnt_r) begin
          best_cnt_nxt = cnt_r;
          best_val_nxt = pivot_r;
        end
        i_nxt     = i_inc;
        state_nxt = (i_inc == fill_r) ? S_EMIT : S_PIV;
      end
      S_EMIT: begin
        out_valid_nxt = 1'b1;
        out_value_nxt = best_val_r;
        out_count_nxt = (32'(best_cnt_r) > 32'd255) ? '1 : ModeCountW'(best_cnt_r);
        out_ovf_nxt   = ovf_r;
        fill_nxt      = '0;
        ovf_nxt       = 1'b0;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      ovf_r       <= 1'b0;
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      ovf_r       <= ovf_nxt;
      rv_r        <= rv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    cnt_r       <= cnt_nxt;
    best_cnt_r  <= best_cnt_nxt;
    best_val_r  <= best_val_nxt;
    pivot_r     <= pivot_nxt;
    out_value_r <= out_value_nxt;
    out_count_r <= out_count_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_mode_value = out_value_r;
  assign out_mode_count = out_count_r;
  assign out_overflowed = out_ovf_r;

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(STORE_DEPTH))
    else $error("fill count beyond store depth");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held longer than one cycle");

  a_last_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_last_item) |=> busy)
    else $error("closing transaction did not start the count pass");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (j_r <= fill_r && i_r < fill_r))
    else $error("scan index outside the stored set");

  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |=> (fill_r == '0 && !ovf_r && out_valid_r))
    else $error("set not cleared after result");
`endif

endmodule
